/* hdl/bary3_pkg.sv */
// Shared constant for the 3D barycentric weight pipeline.
`timescale 1ns / 1ps
package bary3_pkg;

  // Integer bits of a weight, sign included, above its fraction bits.
  localparam int WEIGHT_INT_BITS = 5;

endpackage

/* hdl/barycentric_weights_3d.sv */
// Top level of the 3D barycentric weight pipeline.
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_stall   three vertices and a query point
//   out_     output     out_valid / out_stall three weights and the degenerate flag
//
// One word is accepted every cycle while in_stall is low; the divider has one
// restoring stage for each weight bit.
// Reset is synchronous and active low and clears only the valid bits.
// When a finished word is held by out_stall the whole pipeline holds too.
`timescale 1ns / 1ps
module barycentric_weights_3d import bary3_pkg::*; #(
  parameter int COORD_WIDTH      = 24,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_valid,
  output logic                                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]                     in_vertex_a_x,
  input  logic signed [COORD_WIDTH-1:0]                     in_vertex_a_y,
  input  logic signed [COORD_WIDTH-1:0]                     in_vertex_a_z,
  input  logic signed [COORD_WIDTH-1:0]                     in_vertex_b_x,
  input  logic signed [COORD_WIDTH-1:0]                     in_vertex_b_y,
  input  logic signed [COORD_WIDTH-1:0]                     in_vertex_b_z,
  input  logic signed [COORD_WIDTH-1:0]                     in_vertex_c_x,
  input  logic signed [COORD_WIDTH-1:0]                     in_vertex_c_y,
  input  logic signed [COORD_WIDTH-1:0]                     in_vertex_c_z,
  input  logic signed [COORD_WIDTH-1:0]                     in_point_x,
  input  logic signed [COORD_WIDTH-1:0]                     in_point_y,
  input  logic signed [COORD_WIDTH-1:0]                     in_point_z,
  output logic                                              out_valid,
  input  logic                                              out_stall,
  output logic signed [WEIGHT_FRAC_BITS+WEIGHT_INT_BITS-1:0] out_weight_a,
  output logic signed [WEIGHT_FRAC_BITS+WEIGHT_INT_BITS-1:0] out_weight_b,
  output logic signed [WEIGHT_FRAC_BITS+WEIGHT_INT_BITS-1:0] out_weight_c,
  output logic                                              out_degenerate
);

  localparam int WW  = WEIGHT_FRAC_BITS + WEIGHT_INT_BITS;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int XW  = PW + 1;
  localparam int LW  = (XW + 1) / 2;
  localparam int HW  = XW - LW;
  localparam int PPW = 2 * LW + 2;
  localparam int SW  = 2 * XW + 2;
  localparam int DL  = WW + 4;
  localparam int LAT = 7 + DL;
  localparam int XU [4] = '{0, 3, 2, 0};
  localparam int XV [4] = '{1, 4, 1, 2};

  logic                 en;
  logic [LAT-1:0]       vld_r;
  logic [DL-1:0]        deg_r;

  logic signed [COORD_WIDTH-1:0] vin   [4][3];
  logic signed [COORD_WIDTH-1:0] vin_r [4][3];
  logic signed [DW-1:0]          dif_r [5][3];
  logic signed [PW-1:0]          prd_r [4][6];
  logic signed [XW-1:0]          crs_r [4][3];
  logic signed [PPW-1:0]         pp_r  [4][3][4];
  logic signed [SW-1:0]          trm_r [4][3];
  logic signed [SW-1:0]          dot_r [4];

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld_r[LAT-1];
  assign out_degenerate = deg_r[DL-1];

  assign vin[0] = '{in_vertex_a_x, in_vertex_a_y, in_vertex_a_z};
  assign vin[1] = '{in_vertex_b_x, in_vertex_b_y, in_vertex_b_z};
  assign vin[2] = '{in_vertex_c_x, in_vertex_c_y, in_vertex_c_z};
  assign vin[3] = '{in_point_x, in_point_y, in_point_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vin_r <= vin;
      for (int j = 0; j < 3; j++) begin
        dif_r[0][j] <= DW'(vin_r[1][j]) - DW'(vin_r[0][j]);
        dif_r[1][j] <= DW'(vin_r[2][j]) - DW'(vin_r[0][j]);
        dif_r[2][j] <= DW'(vin_r[3][j]) - DW'(vin_r[0][j]);
        dif_r[3][j] <= DW'(vin_r[3][j]) - DW'(vin_r[1][j]);
        dif_r[4][j] <= DW'(vin_r[3][j]) - DW'(vin_r[2][j]);
      end
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          prd_r[k][2*j]   <= PW'(dif_r[XU[k]][(j+1)%3]) * PW'(dif_r[XV[k]][(j+2)%3]);
          prd_r[k][2*j+1] <= PW'(dif_r[XU[k]][(j+2)%3]) * PW'(dif_r[XV[k]][(j+1)%3]);
          crs_r[k][j]     <= XW'(prd_r[k][2*j]) - XW'(prd_r[k][2*j+1]);
        end
      end
      for (int d = 0; d < 4; d++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[d][j][0] <= PPW'($signed({1'b0, crs_r[0][j][LW-1:0]}))
                         * PPW'($signed({1'b0, crs_r[d][j][LW-1:0]}));
          pp_r[d][j][1] <= PPW'($signed({1'b0, crs_r[0][j][LW-1:0]}))
                         * PPW'($signed(crs_r[d][j][XW-1:LW]));
          pp_r[d][j][2] <= PPW'($signed(crs_r[0][j][XW-1:LW]))
                         * PPW'($signed({1'b0, crs_r[d][j][LW-1:0]}));
          pp_r[d][j][3] <= PPW'($signed(crs_r[0][j][XW-1:LW]))
                         * PPW'($signed(crs_r[d][j][XW-1:LW]));
          trm_r[d][j] <= (SW'(pp_r[d][j][3]) <<< (2 * LW))
                       + ((SW'(pp_r[d][j][1]) + SW'(pp_r[d][j][2])) <<< LW)
                       + SW'(pp_r[d][j][0]);
        end
        dot_r[d] <= trm_r[d][0] + trm_r[d][1] + trm_r[d][2];
      end
      deg_r <= {deg_r[DL-2:0], (dot_r[0] == '0)};
    end
  end

  bary3_div #(.NW(SW), .FRAC(WEIGHT_FRAC_BITS)) u_div_a (
    .clk(clk), .en(en), .num(dot_r[1]), .den(dot_r[0]), .weight(out_weight_a)
  );

  bary3_div #(.NW(SW), .FRAC(WEIGHT_FRAC_BITS)) u_div_b (
    .clk(clk), .en(en), .num(dot_r[2]), .den(dot_r[0]), .weight(out_weight_b)
  );

  bary3_div #(.NW(SW), .FRAC(WEIGHT_FRAC_BITS)) u_div_c (
    .clk(clk), .en(en), .num(dot_r[3]), .den(dot_r[0]), .weight(out_weight_c)
  );

`ifndef NO_ASSERTIONS
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_weight_a == '0 && out_weight_b == '0 && out_weight_c == '0)
    else $error("degenerate word carries non-zero weights");

  a_vld_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[LAT-2]) && $past(en))
    else $error("output valid rose without a word in the last stage");
`endif

endmodule

/* hdl/bary3_div.sv */
// Pipelined rounding divider that turns a dot product ratio into a saturated weight.
`timescale 1ns / 1ps
module bary3_div import bary3_pkg::*; #(
  parameter int NW   = 104,
  parameter int FRAC = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [NW-1:0]                  num,
  input  logic        [NW-1:0]                  den,
  output logic signed [FRAC+WEIGHT_INT_BITS-1:0] weight
);

  localparam int WW = FRAC + WEIGHT_INT_BITS;
  localparam int RW = NW + WW + 2;
  localparam logic [WW-1:0] WLIM = {1'b1, {(WW-1){1'b0}}};

  logic          neg_a_r, zero_a_r;
  logic [NW-1:0] mag_a_r, den_a_r;

  logic          neg_b_r, zero_b_r;
  logic [RW-1:0] rem_b_r;
  logic [NW:0]   d2_b_r;

  logic          neg_r  [WW+1];
  logic          zero_r [WW+1];
  logic          sat_r  [WW+1];
  logic [RW-1:0] rem_r  [WW+1];
  logic [NW:0]   d2_r   [WW+1];
  logic [WW-1:0] q_r    [WW+1];

  logic [WW-1:0]        mq;
  logic signed [WW-1:0] weight_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r  <= num[NW-1];
      zero_a_r <= (den == '0);
      mag_a_r  <= num[NW-1] ? NW'(-num) : NW'(num);
      den_a_r  <= den;

      neg_b_r  <= neg_a_r;
      zero_b_r <= zero_a_r;
      rem_b_r  <= (RW'(mag_a_r) << (FRAC + 1)) + RW'(den_a_r);
      d2_b_r   <= {den_a_r, 1'b0};

      neg_r[0]  <= neg_b_r;
      zero_r[0] <= zero_b_r;
      sat_r[0]  <= (rem_b_r >= (RW'(d2_b_r) << WW));
      rem_r[0]  <= rem_b_r;
      d2_r[0]   <= d2_b_r;
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < WW; k++) begin : g_bit
    localparam int B = WW - 1 - k;
    logic [RW-1:0] sh;
    logic          take;

    assign sh   = RW'(d2_r[k]) << B;
    assign take = (rem_r[k] >= sh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= take ? rem_r[k] - sh : rem_r[k];
        q_r[k+1]    <= q_r[k] | (WW'(take) << B);
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        sat_r[k+1]  <= sat_r[k];
        d2_r[k+1]   <= d2_r[k];
      end
    end
  end

  always_comb begin
    if (!neg_r[WW]) begin
      mq = (sat_r[WW] || q_r[WW][WW-1]) ? WLIM - WW'(1) : q_r[WW];
    end else begin
      mq = (sat_r[WW] || (q_r[WW] > WLIM)) ? WLIM : q_r[WW];
    end
    if (zero_r[WW]) begin
      weight_nxt = '0;
    end else if (neg_r[WW]) begin
      weight_nxt = $signed(WW'(-mq));
    end else begin
      weight_nxt = $signed(mq);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight <= weight_nxt;
    end
  end

endmodule
